@@ hw/rtl/lapc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lapc_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int SPEED_W = 16;
    localparam int QUOT_W  = 15;
    localparam int RANGE_W = 20;
    localparam int ERR_W   = 33;
    localparam int DIST_W  = 16;
    localparam int MCAND_W = 41;
    localparam int PROD_W  = 58;
    localparam int CNT_W   = 4;

    // Step counts for the serial units, counted down to zero
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DIST_W - 1);

    // Opcodes
    localparam logic [1:0] OP_AUTO   = 2'd0;
    localparam logic [1:0] OP_MANUAL = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_TOL   = 3'd0;
    localparam logic [2:0] CFG_RANGE = 3'd1;
    localparam logic [2:0] CFG_MIN   = 3'd2;
    localparam logic [2:0] CFG_MAX   = 3'd3;
    localparam logic [2:0] CFG_MAXH  = 3'd4;
    localparam logic [2:0] CFG_CSQ   = 3'd5;
    localparam logic [2:0] CFG_CLIN  = 3'd6;
    localparam logic [2:0] CFG_COFF  = 3'd7;

    // Drive limits
    localparam logic signed [SPEED_W-1:0] SPEED_MOST_NEG = 16'sh8000;
    localparam logic signed [SPEED_W-1:0] SPEED_NEG_LIM  = 16'sh8001;

    // Rounding bias for truncating a Q.24 value toward zero
    localparam logic [PROD_W-1:0] TRUNC_BIAS = PROD_W'(24'hFF_FFFF);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_ERR,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_VTGT,
        ST_BAND,
        ST_LIMIT,
        ST_OUTPOS,
        ST_OUTDIFF,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [ERR_W-1:0]   dividend;
        logic [RANGE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                       start;
        logic signed [MCAND_W-1:0]  mcand;
        logic [DIST_W-1:0]          mplier;
        logic signed [PROD_W-1:0]   init;
    } t_mul_req;

endpackage

`default_nettype wire

@@ hw/rtl/lapc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: speed = floor(err * 2^15 / range), saturated.
// One quotient bit per cycle after a single overflow check.
module lapc_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  lapc_pkg::t_div_req          i_req,
    output logic                        o_busy,
    output logic [lapc_pkg::QUOT_W-1:0] o_quot
);

    logic                          r_busy, n_busy;
    logic                          r_chk, n_chk;
    logic [lapc_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [lapc_pkg::ERR_W-1:0]    r_rem, n_rem;
    logic [lapc_pkg::RANGE_W-1:0]  r_dvs, n_dvs;
    logic [lapc_pkg::QUOT_W-1:0]   r_quot, n_quot;
    logic [lapc_pkg::RANGE_W:0]    w_shift;
    logic                          w_ge;

    // Shift remainder up one bit and trial-subtract
    assign w_shift = {r_rem[lapc_pkg::RANGE_W-1:0], 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_chk  = r_chk;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quot = r_quot;
        if (i_req.start) begin
            // Load operands; a zero range acts as one
            n_rem  = i_req.dividend;
            n_dvs  = (i_req.divisor == '0) ? lapc_pkg::RANGE_W'(1) : i_req.divisor;
            n_busy = 1'b1;
            n_chk  = 1'b1;
            n_cnt  = lapc_pkg::DIV_LAST;
            n_quot = '0;
        end else if (r_busy) begin
            if (r_chk) begin
                // Error at or beyond range saturates to full speed
                if (r_rem >= {{(lapc_pkg::ERR_W-lapc_pkg::RANGE_W){1'b0}}, r_dvs}) begin
                    n_quot = '1;
                    n_busy = 1'b0;
                end else begin
                    n_chk = 1'b0;
                end
            end else begin
                n_rem  = {{(lapc_pkg::ERR_W-lapc_pkg::RANGE_W-1){1'b0}},
                          (w_ge ? (w_shift - {1'b0, r_dvs}) : w_shift)};
                n_quot = {r_quot[lapc_pkg::QUOT_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_busy = 1'b0;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chk  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_chk  <= n_chk;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ hw/rtl/lapc_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier: prod = init + mcand * mplier, mplier unsigned.
// Takes one multiplier bit per cycle, lowest first.
module lapc_mul (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lapc_pkg::t_mul_req                 i_req,
    output logic                               o_busy,
    output logic signed [lapc_pkg::PROD_W-1:0] o_prod
);

    logic                               r_busy, n_busy;
    logic [lapc_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [lapc_pkg::PROD_W-1:0] r_acc, n_acc;
    logic [lapc_pkg::PROD_W-1:0]        r_mcand, n_mcand;
    logic [lapc_pkg::DIST_W-1:0]        r_mplier, n_mplier;

    always_comb begin
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_req.start) begin
            n_acc    = i_req.init;
            n_mcand  = {{(lapc_pkg::PROD_W-lapc_pkg::MCAND_W){i_req.mcand[lapc_pkg::MCAND_W-1]}},
                        i_req.mcand};
            n_mplier = i_req.mplier;
            n_cnt    = lapc_pkg::MUL_LAST;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            // Add the shifted multiplicand where the multiplier bit is set
            if (r_mplier[0]) begin
                n_acc = r_acc + $signed(r_mcand);
            end
            n_mcand  = {r_mcand[lapc_pkg::PROD_W-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[lapc_pkg::DIST_W-1:1]};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

@@ hw/rtl/limited_axis_position_controller_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// From acceptance to the output register a set-target word passes ST_OUTPOS, ST_OUTDIFF
// and ST_OUTPUT; a manual word adds ST_POS and ST_LIMIT, an automatic word the 15-step
// restoring divider, and a word with vision the two 16-step shift-add multiplies as well.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset (synchronous, active low) clears target, home offset and drive and loads defaults.
module limited_axis_position_controller_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // slave side
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] encoder_raw, [32] home_switch, [33] vision_on, [49:34] target_distance,
    // [65:50] manual_speed, [97:66] new_target, [103:98] zero
    input  wire  [103:0] s_axis_tdata,
    // [1:0] opcode
    input  wire  [1:0]   s_axis_tuser,
    // master side
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [15:0] motor_drive, [47:16] position, [48] on_target, [55:49] zero
    output logic [55:0]  m_axis_tdata,
    // configuration writes
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_addr,
    input  wire  [31:0]  i_cfg_wdata
);

    lapc_pkg::t_state r_state, n_state;

    // Latched input word
    logic [1:0]          r_op;
    logic [31:0]         r_raw;
    logic                r_home;
    logic                r_vision;
    logic [15:0]         r_dist;
    logic signed [15:0]  r_ms;

    // Axis state
    logic signed [31:0]  r_target, n_target;
    logic [31:0]         r_offset, n_offset;
    logic signed [15:0]  r_drive, n_drive;

    // Working registers
    logic [31:0]         r_pos, n_pos;
    logic signed [32:0]  r_diff, n_diff;
    logic signed [15:0]  r_speed, n_speed;
    logic signed [33:0]  r_vsum, n_vsum;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic signed [15:0]  r_out_drive, n_out_drive;
    logic [31:0]         r_out_pos, n_out_pos;
    logic                r_out_on, n_out_on;

    // Configuration
    logic [15:0]         r_tol;
    logic [19:0]         r_range;
    logic [14:0]         r_min;
    logic [14:0]         r_max;
    logic [30:0]         r_maxh;
    logic signed [31:0]  r_csq;
    logic signed [31:0]  r_clin;
    logic signed [31:0]  r_coff;

    lapc_pkg::t_div_req  w_div_req;
    lapc_pkg::t_mul_req  w_mul_req;
    logic                w_div_busy;
    logic [14:0]         w_quot;
    logic                w_mul_busy;
    logic signed [57:0]  w_prod;

    logic                w_in_acc;
    logic                w_out_free;
    logic [31:0]         w_pos_now;
    logic signed [32:0]  w_dpos;
    logic [32:0]         w_err;
    logic [14:0]         w_q_lim;
    logic [14:0]         w_q_clamp;
    logic signed [40:0]  w_mcand2;
    logic [57:0]         w_vbias;
    logic signed [32:0]  w_tol_s;
    logic signed [32:0]  w_ntol_s;
    logic                w_above;
    logic                w_below;
    logic                w_at_top;
    logic signed [15:0]  w_spd;
    logic                w_apply;

    assign s_axis_tready = (r_state == lapc_pkg::ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Position and absolute error against the stored target
    assign w_pos_now = r_raw - r_offset;
    assign w_dpos    = $signed({r_pos[31], r_pos}) - $signed({r_target[31], r_target});
    assign w_err     = w_dpos[32] ? 33'(-w_dpos) : 33'(w_dpos);

    // Clamp the quotient: max first, then min wins
    assign w_q_lim   = (w_quot > r_max) ? r_max : w_quot;
    assign w_q_clamp = (w_q_lim < r_min) ? r_min : w_q_lim;

    // floor(sq*d/256) + lin, then truncate the Q.24 sum toward zero
    assign w_mcand2 = $signed(w_prod[48:8]) + $signed({{9{r_clin[31]}}, r_clin});
    assign w_vbias  = w_prod + (w_prod[57] ? lapc_pkg::TRUNC_BIAS : '0);

    // Tolerance band around the target
    assign w_tol_s  = $signed({17'b0, r_tol});
    assign w_ntol_s = -w_tol_s;
    assign w_above  = (r_diff > w_tol_s);
    assign w_below  = (r_diff < w_ntol_s);

    // Height limit, seen from the position after any re-homing
    assign w_at_top = r_home ? (r_maxh == '0)
                             : (!r_pos[31] && (r_pos[30:0] >= r_maxh));

    // Drive request for the limit stage
    always_comb begin
        w_spd   = r_speed;
        w_apply = 1'b1;
        if (r_op == lapc_pkg::OP_AUTO) begin
            if (w_above) begin
                w_spd = -r_speed;
            end else if (w_below) begin
                w_spd = r_speed;
            end else begin
                w_spd   = '0;
                w_apply = 1'b0;
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_target    = r_target;
        n_offset    = r_offset;
        n_drive     = r_drive;
        n_pos       = r_pos;
        n_diff      = r_diff;
        n_speed     = r_speed;
        n_vsum      = r_vsum;
        n_out_valid = r_out_valid;
        n_out_drive = r_out_drive;
        n_out_pos   = r_out_pos;
        n_out_on    = r_out_on;

        w_div_req          = '0;
        w_div_req.dividend = w_err;
        w_div_req.divisor  = r_range;

        w_mul_req        = '0;
        w_mul_req.mplier = r_dist;
        w_mul_req.mcand  = {{9{r_csq[31]}}, r_csq};

        // Drop the output word once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            lapc_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (s_axis_tuser) inside
                        lapc_pkg::OP_AUTO,
                        lapc_pkg::OP_MANUAL: n_state = lapc_pkg::ST_POS;
                        lapc_pkg::OP_SET: begin
                            n_target = $signed(s_axis_tdata[97:66]);
                            n_state  = lapc_pkg::ST_OUTPOS;
                        end
                        default: n_state = lapc_pkg::ST_OUTPOS;
                    endcase
                end
            end
            lapc_pkg::ST_POS: begin
                n_pos = w_pos_now;
                if (r_op == lapc_pkg::OP_AUTO) begin
                    n_state = lapc_pkg::ST_ERR;
                end else begin
                    n_speed = (r_ms == lapc_pkg::SPEED_MOST_NEG) ? lapc_pkg::SPEED_NEG_LIM : r_ms;
                    n_state = lapc_pkg::ST_LIMIT;
                end
            end
            lapc_pkg::ST_ERR: begin
                // Start the divider, and the square term when vision is on
                w_div_req.start = 1'b1;
                w_mul_req.start = r_vision;
                n_state         = lapc_pkg::ST_DIV;
            end
            lapc_pkg::ST_DIV: begin
                if (!w_div_busy) begin
                    n_speed = $signed({1'b0, w_q_clamp});
                    n_state = r_vision ? lapc_pkg::ST_MUL1 : lapc_pkg::ST_BAND;
                end
            end
            lapc_pkg::ST_MUL1: begin
                if (!w_mul_busy) begin
                    w_mul_req.start = 1'b1;
                    w_mul_req.mcand = w_mcand2;
                    w_mul_req.init  = $signed({{18{r_coff[31]}}, r_coff, 8'b0});
                    n_state         = lapc_pkg::ST_MUL2;
                end
            end
            lapc_pkg::ST_MUL2: begin
                if (!w_mul_busy) begin
                    n_vsum  = $signed(w_vbias[57:24]);
                    n_state = lapc_pkg::ST_VTGT;
                end
            end
            lapc_pkg::ST_VTGT: begin
                // Saturate the vision target to 32 bits
                if ((r_vsum[33:31] == 3'b000) || (r_vsum[33:31] == 3'b111)) begin
                    n_target = r_vsum[31:0];
                end else begin
                    n_target = r_vsum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                n_state = lapc_pkg::ST_BAND;
            end
            lapc_pkg::ST_BAND: begin
                n_diff  = w_dpos;
                n_state = lapc_pkg::ST_LIMIT;
            end
            lapc_pkg::ST_LIMIT: begin
                if (!w_apply) begin
                    n_drive = '0;
                end else begin
                    if (r_home) begin
                        n_offset = r_raw;
                    end
                    if (r_home && w_spd[15]) begin
                        n_drive = '0;
                    end else if (w_at_top && !w_spd[15] && (w_spd != '0)) begin
                        n_drive = '0;
                    end else begin
                        n_drive = w_spd;
                    end
                end
                n_state = lapc_pkg::ST_OUTPOS;
            end
            lapc_pkg::ST_OUTPOS: begin
                n_pos   = w_pos_now;
                n_state = lapc_pkg::ST_OUTDIFF;
            end
            lapc_pkg::ST_OUTDIFF: begin
                n_diff  = w_dpos;
                n_state = lapc_pkg::ST_OUTPUT;
            end
            lapc_pkg::ST_OUTPUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_drive = r_drive;
                    n_out_pos   = r_pos;
                    n_out_on    = (r_diff >= w_ntol_s) && (r_diff <= w_tol_s);
                    n_state     = lapc_pkg::ST_IDLE;
                end
            end
            default: n_state = lapc_pkg::ST_IDLE;
        endcase
    end

    // Control and axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lapc_pkg::ST_IDLE;
            r_target    <= '0;
            r_offset    <= '0;
            r_drive     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_target    <= n_target;
            r_offset    <= n_offset;
            r_drive     <= n_drive;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and output payload
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_diff      <= n_diff;
        r_speed     <= n_speed;
        r_vsum      <= n_vsum;
        r_out_drive <= n_out_drive;
        r_out_pos   <= n_out_pos;
        r_out_on    <= n_out_on;
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op     <= s_axis_tuser;
            r_raw    <= s_axis_tdata[31:0];
            r_home   <= s_axis_tdata[32];
            r_vision <= s_axis_tdata[33];
            r_dist   <= s_axis_tdata[49:34];
            r_ms     <= $signed(s_axis_tdata[65:50]);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= 16'd10;
            r_range <= 20'd200;
            r_min   <= 15'd3277;
            r_max   <= 15'd16384;
            r_maxh  <= 31'd1000;
            r_csq   <= '0;
            r_clin  <= '0;
            r_coff  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                lapc_pkg::CFG_TOL:   r_tol   <= i_cfg_wdata[15:0];
                lapc_pkg::CFG_RANGE: r_range <= i_cfg_wdata[19:0];
                lapc_pkg::CFG_MIN:   r_min   <= i_cfg_wdata[14:0];
                lapc_pkg::CFG_MAX:   r_max   <= i_cfg_wdata[14:0];
                lapc_pkg::CFG_MAXH:  r_maxh  <= i_cfg_wdata[30:0];
                lapc_pkg::CFG_CSQ:   r_csq   <= $signed(i_cfg_wdata);
                lapc_pkg::CFG_CLIN:  r_clin  <= $signed(i_cfg_wdata);
                lapc_pkg::CFG_COFF:  r_coff  <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    lapc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    lapc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_busy  (w_mul_busy),
        .o_prod  (w_prod)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_on, r_out_pos, r_out_drive};

endmodule

`default_nettype wire

@@ hw/rtl/lapc_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lapc_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [55:0]  m_axis_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // One word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word accepted while previous one in flight");

    // A new result only comes out of a word in flight
    a_result_from_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared with no word in flight");

    // Drive never reaches the most negative code
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] != 16'h8000))
        else $error("drive out of range");

endmodule

bind limited_axis_position_controller_unit lapc_chk u_lapc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ dv/lapc_tick_checker.sv @@
`timescale 1ns / 1ps

module lapc_tick_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    // [31:0] encoder_raw, [32] home_switch, [33] vision_on, [49:34] target_distance,
    // [65:50] manual_speed, [97:66] new_target, [103:98] zero
    input  wire  [103:0] i_s_tdata,
    // [1:0] opcode
    input  wire  [1:0]   i_s_tuser,
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    // [15:0] motor_drive, [47:16] position, [48] on_target, [55:49] zero
    input  wire  [55:0]  i_m_tdata,
    input  wire          i_cfg_we,
    input  wire  [2:0]   i_cfg_addr,
    input  wire  [31:0]  i_cfg_wdata,
    output int           o_fail_count,
    output int           o_pending
);

    localparam longint SPEED_TOP = 64'sd32767;
    localparam longint AIM_HI    = 64'sd2147483647;
    localparam longint AIM_LO    = -64'sd2147483648;
    localparam longint Q24_ONE   = 64'sd16777216;

    typedef struct packed {
        logic signed [15:0] drive;
        logic [31:0]        pos;
        logic               on_tgt;
    } t_tick_result;

    t_tick_result expected_results[$];

    // Register copies
    logic [15:0]        tol_cfg;
    logic [19:0]        range_cfg;
    logic [14:0]        min_spd;
    logic [14:0]        max_spd;
    logic [30:0]        maxh_cfg;
    logic signed [31:0] csq;
    logic signed [31:0] clin;
    logic signed [31:0] coff;

    // Axis state
    logic signed [31:0] tgt_pos;
    logic [31:0]        home_off;
    logic signed [15:0] drive_hold;

    // Apply the home switch and the travel limits to a requested drive
    function automatic void steer(input int req, input logic [31:0] raw, input logic home);
        longint pos_l;
        if (home) home_off = raw;
        pos_l = longint'($signed(raw - home_off));
        if (home && req < 0)
            drive_hold = '0;
        else if (pos_l >= longint'(maxh_cfg) && req > 0)
            drive_hold = '0;
        else
            drive_hold = 16'(req);
    endfunction

    // Advance the axis state by one tick and return the word it should report
    function automatic t_tick_result predict_tick(input logic [1:0] op, input logic [103:0] w);
        logic [31:0]        raw;
        logic               home;
        logic               vis;
        logic [15:0]        tgt_dist;
        logic signed [15:0] ms;
        longint             pos_l, tgt_l, tol_l, err, span, quo, prod, acc, aim;
        int                 spd;
        t_tick_result       r;
        raw      = w[31:0];
        home     = w[32];
        vis      = w[33];
        tgt_dist = w[49:34];
        ms       = w[65:50];
        tol_l    = longint'(tol_cfg);
        case (op)
            lapc_pkg::OP_AUTO: begin
                // speed from the error before any re-homing
                pos_l = longint'($signed(raw - home_off));
                tgt_l = longint'(tgt_pos);
                err   = (pos_l > tgt_l) ? pos_l - tgt_l : tgt_l - pos_l;
                span  = (range_cfg == '0) ? 64'sd1 : longint'(range_cfg);
                quo   = (err * 64'sd32768) / span;
                if (quo > SPEED_TOP) quo = SPEED_TOP;
                if (quo > longint'(max_spd)) quo = longint'(max_spd);
                if (quo < longint'(min_spd)) quo = longint'(min_spd);
                spd = int'(quo);
                // quadratic of distance, floor the square term at Q.24, truncate the Q.24 sum
                if (vis) begin
                    prod = (longint'(csq) * longint'(tgt_dist)) >>> 8;
                    acc  = prod * longint'(tgt_dist) + longint'(clin) * longint'(tgt_dist)
                         + longint'(coff) * 64'sd256;
                    aim  = acc / Q24_ONE;
                    if (aim > AIM_HI) aim = AIM_HI;
                    if (aim < AIM_LO) aim = AIM_LO;
                    tgt_pos = aim[31:0];
                end
                tgt_l = longint'(tgt_pos);
                if (pos_l > tgt_l + tol_l)
                    steer(-spd, raw, home);
                else if (pos_l < tgt_l - tol_l)
                    steer(spd, raw, home);
                else
                    drive_hold = '0;
            end
            lapc_pkg::OP_MANUAL: begin
                steer((ms == lapc_pkg::SPEED_MOST_NEG) ? int'(lapc_pkg::SPEED_NEG_LIM)
                                                       : int'(ms), raw, home);
            end
            lapc_pkg::OP_SET: begin
                tgt_pos = w[97:66];
            end
            default: ;
        endcase
        pos_l    = longint'($signed(raw - home_off));
        tgt_l    = longint'(tgt_pos);
        r.drive  = drive_hold;
        r.pos    = raw - home_off;
        r.on_tgt = (pos_l >= tgt_l - tol_l) && (pos_l <= tgt_l + tol_l);
        return r;
    endfunction

    // Watch the channels: check results, predict from inputs, track register writes
    always @(posedge i_clk) begin
        t_tick_result exp_w;
        t_tick_result got_w;
        if (!i_rst_n) begin
            tol_cfg      = 16'd10;
            range_cfg    = 20'd200;
            min_spd      = 15'd3277;
            max_spd      = 15'd16384;
            maxh_cfg     = 31'd1000;
            csq          = '0;
            clin         = '0;
            coff         = '0;
            tgt_pos      = '0;
            home_off     = '0;
            drive_hold   = '0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_w.drive  = i_m_tdata[15:0];
                got_w.pos    = i_m_tdata[47:16];
                got_w.on_tgt = i_m_tdata[48];
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected word: drive %0d position %0d on_target %0b",
                                 $signed(got_w.drive), $signed(got_w.pos), got_w.on_tgt);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_w = expected_results.pop_front();
                    if (got_w.drive != exp_w.drive || got_w.pos != exp_w.pos
                        || got_w.on_tgt != exp_w.on_tgt) begin
                        if (o_fail_count < 10)
                            $display({"mismatch (exp/got): drive %0d/%0d position %0d/%0d",
                                      " on_target %0b/%0b"},
                                     $signed(exp_w.drive), $signed(got_w.drive),
                                     $signed(exp_w.pos), $signed(got_w.pos),
                                     exp_w.on_tgt, got_w.on_tgt);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(predict_tick(i_s_tuser, i_s_tdata));
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    lapc_pkg::CFG_TOL:   tol_cfg   = i_cfg_wdata[15:0];
                    lapc_pkg::CFG_RANGE: range_cfg = i_cfg_wdata[19:0];
                    lapc_pkg::CFG_MIN:   min_spd   = i_cfg_wdata[14:0];
                    lapc_pkg::CFG_MAX:   max_spd   = i_cfg_wdata[14:0];
                    lapc_pkg::CFG_MAXH:  maxh_cfg  = i_cfg_wdata[30:0];
                    lapc_pkg::CFG_CSQ:   csq       = i_cfg_wdata;
                    lapc_pkg::CFG_CLIN:  clin      = i_cfg_wdata;
                    lapc_pkg::CFG_COFF:  coff      = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ dv/tb_limited_axis_position_controller_unit.sv @@
`timescale 1ns / 1ps

module tb_limited_axis_position_controller_unit;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [103:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [55:0]  m_axis_tdata;
    logic         i_cfg_we      = 1'b0;
    logic [2:0]   i_cfg_addr    = '0;
    logic [31:0]  i_cfg_wdata   = '0;

    int mismatches;
    int in_flight;
    int cycle_count;

    // Stimulus shaping: rough view of the axis and the current register set
    int unsigned tol_set   = 10;
    int unsigned range_set = 200;
    int unsigned maxh_set  = 1000;
    int          aim_target = 0;
    logic [31:0] home_raw   = '0;
    bit          tx_idle  = 1'b1;
    bit          rx_idle  = 1'b1;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    limited_axis_position_controller_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    lapc_tick_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (mismatches),
        .o_pending    (in_flight)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Give up well past the slowest correct run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("status: fail");
        $finish;
    end

    // Stall the result side in random bursts
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
            if (stall == 0 && rx_idle && !rx_quiet && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 9);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall = stall - 1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    function automatic int rand_span(input int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    // Offer one word, after an optional gap, and hold it until taken
    task automatic send_tick(input logic [1:0] op, input logic [31:0] raw, input logic home,
                             input logic vis, input logic [15:0] tgt_dist,
                             input logic [15:0] ms, input logic [31:0] nt);
        int gap;
        gap = 0;
        if (tx_idle && !tx_quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tuser  = op;
        s_axis_tdata  = {6'b0, nt, ms, tgt_dist, vis, home, raw};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (home) home_raw = raw;
        if (op == lapc_pkg::OP_SET) aim_target = nt;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (in_flight != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
    endtask

    // Load a full register set while the block is idle
    task automatic program_regs(input int unsigned tol, input int unsigned rng,
                                input int unsigned mn, input int unsigned mx,
                                input int unsigned mh, input logic [31:0] sq,
                                input logic [31:0] ln, input logic [31:0] of);
        settle();
        write_reg(lapc_pkg::CFG_TOL, tol);
        write_reg(lapc_pkg::CFG_RANGE, rng);
        write_reg(lapc_pkg::CFG_MIN, mn);
        write_reg(lapc_pkg::CFG_MAX, mx);
        write_reg(lapc_pkg::CFG_MAXH, mh);
        write_reg(lapc_pkg::CFG_CSQ, sq);
        write_reg(lapc_pkg::CFG_CLIN, ln);
        write_reg(lapc_pkg::CFG_COFF, of);
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        tol_set   = tol;
        range_set = rng;
        maxh_set  = mh;
    endtask

    // Mostly ticks near the target and the height limit, the rest plain noise
    task automatic random_ticks(input int n);
        logic [1:0]  op;
        logic [31:0] raw;
        logic [31:0] nt;
        logic        home;
        logic        vis;
        logic [15:0] tgt_dist;
        logic [15:0] ms;
        int          r;
        int          scale;
        repeat (n) begin
            if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
            tgt_dist = 16'($urandom);
            ms       = 16'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                op   = 2'($urandom);
                raw  = $urandom;
                nt   = $urandom;
                home = 1'($urandom);
                vis  = 1'($urandom);
            end else begin
                r  = $urandom_range(0, 99);
                op = (r < 50) ? lapc_pkg::OP_AUTO
                   : (r < 72) ? lapc_pkg::OP_MANUAL
                   : (r < 96) ? lapc_pkg::OP_SET : OP_SPARE;
                case ($urandom_range(0, 3))
                    0: scale = tol_set + 2;
                    1: scale = 2 * range_set;
                    2: scale = 4096;
                    default: scale = 1 << 24;
                endcase
                if (scale > (1 << 24) || scale < 1) scale = 1 << 24;
                raw  = home_raw + aim_target + rand_span(scale);
                nt   = ($urandom_range(0, 2) == 0) ? maxh_set + rand_span(scale)
                                                   : aim_target + rand_span(scale);
                home = ($urandom_range(0, 11) == 0);
                vis  = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 19) == 0) begin
                    case ($urandom_range(0, 2))
                        0: ms = 16'h8000;
                        1: ms = 16'h8001;
                        default: ms = 16'h7FFF;
                    endcase
                end
            end
            send_tick(op, raw, home, vis, tgt_dist, ms, nt);
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: limits, re-homing, band and extreme fields
        send_tick(lapc_pkg::OP_MANUAL, 32'd0, 1'b0, 1'b0, 16'd0, 16'h7FFF, 32'd0);
        send_tick(lapc_pkg::OP_MANUAL, 32'd1000, 1'b0, 1'b0, 16'd0, 16'd1, 32'd0);
        send_tick(lapc_pkg::OP_MANUAL, 32'd5, 1'b0, 1'b0, 16'd0, 16'h8000, 32'd0);
        send_tick(lapc_pkg::OP_MANUAL, 32'd77, 1'b1, 1'b0, 16'd0, -16'sd5, 32'd0);
        send_tick(lapc_pkg::OP_MANUAL, 32'd77, 1'b1, 1'b0, 16'd0, 16'd123, 32'd0);
        send_tick(lapc_pkg::OP_SET, 32'd77, 1'b0, 1'b0, 16'd0, 16'd0, 32'd500);
        send_tick(lapc_pkg::OP_AUTO, 32'd77, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_AUTO, 32'd572, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_AUTO, 32'd677, 1'b1, 1'b0, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_AUTO, 32'd1170, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_AUTO, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_AUTO, 32'h8000_0000, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0);
        send_tick(OP_SPARE, $urandom, 1'b1, 1'b1, 16'hFFFF, 16'h8000, $urandom);
        send_tick(lapc_pkg::OP_SET, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 32'h7FFF_FFFF);
        send_tick(lapc_pkg::OP_AUTO, 32'h8000_0000, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_SET, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 32'h8000_0000);
        send_tick(lapc_pkg::OP_AUTO, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_AUTO, 32'd0, 1'b0, 1'b1, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_AUTO, 32'd500, 1'b0, 1'b1, 16'hFFFF, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_MANUAL, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0);

        // Upper extremes: zero band and range, saturating vision target
        program_regs(0, 0, 0, 32767, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_tick(lapc_pkg::OP_AUTO, 32'd0, 1'b0, 1'b1, 16'hFFFF, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_AUTO, 32'd0, 1'b0, 1'b1, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_MANUAL, 32'd100, 1'b0, 1'b0, 16'd0, 16'd1, 32'd0);
        random_ticks(60);

        // Lower extremes: minimum above maximum, negative saturation
        program_regs(65535, 1048575, 32767, 0, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_tick(lapc_pkg::OP_AUTO, 32'd0, 1'b0, 1'b1, 16'hFFFF, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_AUTO, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0, 16'd0, 32'd0);
        send_tick(lapc_pkg::OP_MANUAL, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0, 16'h7FFF, 32'd0);
        random_ticks(60);

        // Random settings around realistic operating points
        repeat (6) begin
            program_regs($urandom_range(0, 48),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1048575)
                                                     : $urandom_range(1, 3000),
                         $urandom_range(0, 6000), $urandom_range(3000, 32767),
                         ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3000)
                                                     : $urandom_range(0, 200000),
                         rand_span(1 << 12), rand_span(1 << 20), rand_span(1 << 26));
            random_ticks(80);
        end

        // Closing stretch at full rate on both sides
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        random_ticks(80);

        settle();
        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && in_flight == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/lapc_pkg.sv
hw/rtl/lapc_div.sv
hw/rtl/lapc_mul.sv
hw/rtl/limited_axis_position_controller_unit.sv
hw/rtl/lapc_chk.sv
dv/lapc_tick_checker.sv
dv/tb_limited_axis_position_controller_unit.sv
